// ----- hw/rtl/isf_pkg.sv -----
// shared types and constants for the independent set fitness block
package isf_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int VCOUNT_W         = 7;
   localparam int ROW_IDX_W        = 6;
   localparam int VEC_W            = 64;
   localparam int FIT_W            = 7;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } op_type;

   typedef struct packed {
      op_type               opcode;
      logic [ROW_IDX_W-1:0] row_index;
      logic [VEC_W-1:0]     bit_vector;
   } req_type;

   typedef struct packed {
      logic             valid_res;
      logic [FIT_W-1:0] fitness;
   } rsp_type;

   // control part of the item travelling down the chain
   typedef struct packed {
      logic                 valid;
      logic                 eval;
      logic [ROW_IDX_W-1:0] row_index;
      logic                 conflict;
      logic [FIT_W-1:0]     count;
   } link_type;

endpackage

// ----- hw/rtl/independent_set_fitness.sv -----
// top level: independent set check with cardinality over a chain of row cells
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_type (opcode, row_index, bit_vector)
//  rsp      out        rsp_valid/rsp_ready    rsp_type (valid_res, fitness)
//  csr      in         csr_valid/csr_ready    vertex_count, 7 bits
//
// every item is taken into the first of MAX_VERTICES cells and moves one cell per cycle
// while the chain advances; at the tail an evaluate item loads its result into the output
// register.
// one item may enter per cycle while req_ready is high; write items give no result.
// the whole chain stalls only while an evaluate result waits at the tail behind a full
// output register; reset clears the chain and output valid, adjacency rows stay undefined.
module independent_set_fitness
   import isf_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [VCOUNT_W-1:0] csr_data
);

   logic [VCOUNT_W-1:0]     vcount_ff;
   logic [MAX_VERTICES-1:0] use_mask;
   link_type                link_chain [MAX_VERTICES+1];
   logic [MAX_VERTICES-1:0] vec_chain  [MAX_VERTICES+1];
   logic                    advance;
   logic                    tail_eval;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         vcount_ff <= csr_data;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         use_mask[i] = VCOUNT_W'(i) < vcount_ff;
      end
   end

   // chain entry
   always_comb begin
      link_chain[0].valid     = req_valid;
      link_chain[0].eval      = (req_payload.opcode == OP_EVAL);
      link_chain[0].row_index = req_payload.row_index;
      link_chain[0].conflict  = 1'b0;
      link_chain[0].count     = '0;
      if (req_payload.opcode == OP_EVAL) begin
         vec_chain[0] = req_payload.bit_vector[MAX_VERTICES-1:0] & use_mask;
      end else begin
         vec_chain[0] = req_payload.bit_vector[MAX_VERTICES-1:0];
      end
   end

   for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
      isf_cell #(
         .MAX_VERTICES (MAX_VERTICES),
         .CELL_INDEX   (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_link  (link_chain[g]),
         .in_vec   (vec_chain[g]),
         .out_link (link_chain[g+1]),
         .out_vec  (vec_chain[g+1])
      );
   end

   assign tail_eval = link_chain[MAX_VERTICES].valid && link_chain[MAX_VERTICES].eval;
   assign advance   = !tail_eval || !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign rsp_valid_in = tail_eval || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail_eval) begin
         rsp_ff.valid_res <= !link_chain[MAX_VERTICES].conflict;
         rsp_ff.fitness   <= link_chain[MAX_VERTICES].conflict ?
                             '0 : link_chain[MAX_VERTICES].count;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- hw/rtl/isf_cell.sv -----
// one chain cell: holds one adjacency row and checks its vertex against the passing subset
module isf_cell
   import isf_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int CELL_INDEX   = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  link_type                in_link,
   input  logic [MAX_VERTICES-1:0] in_vec,
   output link_type                out_link,
   output logic [MAX_VERTICES-1:0] out_vec
);

   logic [MAX_VERTICES-1:0] row_ff;
   link_type                link_ff;
   link_type                link_in;
   logic [MAX_VERTICES-1:0] vec_ff;
   logic                    hit;
   logic                    row_write;

   assign row_write = in_link.valid && !in_link.eval &&
                      (in_link.row_index == ROW_IDX_W'(CELL_INDEX));
   assign hit       = in_link.valid && in_link.eval && in_vec[CELL_INDEX];

   always_comb begin
      link_in          = in_link;
      link_in.conflict = in_link.conflict | (hit && (|(row_ff & in_vec)));
      link_in.count    = in_link.count + FIT_W'(hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else if (advance) begin
         link_ff <= link_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= in_vec;
      end
      if (advance && row_write) begin
         row_ff <= in_vec;
      end
   end

   assign out_link = link_ff;
   assign out_vec  = vec_ff;

endmodule

// ----- hw/rtl/isf_checker.sv -----
// port-level checks for the independent set fitness block, bound to the top level
module isf_checker
   import isf_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.valid_res |-> rsp_payload.fitness == '0)
      else $error("non-independent subset with non-zero fitness");

   a_fit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.fitness <= FIT_W'(MAX_VERTICES))
      else $error("fitness above vertex limit");

   // chain only stalls behind a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a pending result");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind independent_set_fitness isf_checker #(
   .MAX_VERTICES (MAX_VERTICES)
) u_isf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
